// ----- src/skrt_pkg.sv -----
// Shared types and codes for the sorted keyed record table.
`default_nettype none

package skrt_pkg;

   localparam int KEY_W = 32;
   localparam int PAY_W = 8;
   localparam int CNT_W = 7;

   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_LOOKUP = 3'd1;
   localparam logic [2:0] MODE_UPDATE = 3'd2;
   localparam logic [2:0] MODE_DELETE = 3'd3;
   localparam logic [2:0] MODE_LIST   = 3'd4;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_DUP      = 3'd2;
   localparam logic [2:0] STAT_NOTFOUND = 3'd3;
   localparam logic [2:0] STAT_EMPTY    = 3'd4;

   typedef struct packed {
      logic [2:0]              mode;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic signed [KEY_W-1:0] rec_key;
      logic [PAY_W-1:0]        rec_payload;
      logic [CNT_W-1:0]        entry_count;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
   } rec_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_type;

endpackage

`default_nettype wire

// ----- src/skrt_keycmp.sv -----
// Signed key compare unit shared by every scan of the table.
`default_nettype none

module skrt_keycmp (
   input  wire logic signed [skrt_pkg::KEY_W-1:0] stored_key,
   input  wire logic signed [skrt_pkg::KEY_W-1:0] probe_key,
   output skrt_pkg::cmp_type                      cmp
);

   // lt: stored entry sorts below the probe
   always_comb begin
      cmp.eq = (stored_key == probe_key);
      cmp.lt = (stored_key < probe_key);
   end

endmodule

`default_nettype wire

// ----- src/skrt_mem.sv -----
// Record store: one write port, one read port with registered read data.
`default_nettype none

module skrt_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire skrt_pkg::rec_type wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output skrt_pkg::rec_type      rd_data
);

   skrt_pkg::rec_type mem_ff [DEPTH];
   skrt_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/sorted_keyed_record_table_unit.sv -----
// Top level of the sorted keyed record table: sequencer, record store and key compare.
// Sequencing: full or empty rejects answer in the cycle after start; other requests scan
//   one entry a cycle, and insert and delete then shift entries through the single-read-port
//   store before the result is issued.
// List: results stream one a cycle.
// Throughput: one request at a time; busy stays high until the last result is issued.
// Reset (synchronous, active high) empties the table; the store itself is not cleared.
`default_nettype none

module sorted_keyed_record_table_unit #(
   parameter int DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire skrt_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output skrt_pkg::rsp_type      rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] ONE      = CW'(1);
   localparam logic [CW-1:0] ZERO     = CW'(0);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_LIST  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;       // records held
   skrt_pkg::req_type req_ff, req_in;       // request word being served
   logic [CW-1:0]     idx_ff, idx_in;       // next read index / shift destination
   logic              pend_ff, pend_in;     // a read was issued last cycle
   logic [CW-1:0]     pend_idx_ff, pend_idx_in;
   logic [CW-1:0]     pos_ff, pos_in;       // slot found by the scan
   skrt_pkg::rec_type fnd_ff, fnd_in;       // record removed by delete
   logic              rsp_strobe_ff, rsp_strobe_in;
   skrt_pkg::rsp_type rsp_ff, rsp_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   skrt_pkg::rec_type wr_data, rd_data;
   skrt_pkg::cmp_type cmp;

   logic              accept, issue, stop, ins;
   logic [CW-1:0]     hit_pos, src_idx;
   logic [CW+skrt_pkg::CNT_W-1:0] cnt_wide;

   skrt_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   skrt_keycmp u_cmp (
      .stored_key (rd_data.key),
      .probe_key  (req_ff.key),
      .cmp        (cmp)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign ins    = (req_ff.mode == skrt_pkg::MODE_INSERT);

   // shift direction: insert moves entries up, delete moves them down
   assign src_idx = ins ? (idx_ff - ONE) : (idx_ff + ONE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      pend_idx_in   = idx_ff;
      pos_in        = pos_ff;
      fnd_in        = fnd_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rsp_in.last   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = pend_idx_ff[AW-1:0];
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      issue         = 1'b0;
      stop          = 1'b0;
      hit_pos       = cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               idx_in = ZERO;
               if (req_data.mode == skrt_pkg::MODE_INSERT && cnt_ff == FULL_CNT) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = skrt_pkg::STAT_FULL;
               end else if (req_data.mode inside {skrt_pkg::MODE_LOOKUP,
                                                  skrt_pkg::MODE_UPDATE,
                                                  skrt_pkg::MODE_DELETE,
                                                  skrt_pkg::MODE_LIST}
                            && cnt_ff == ZERO) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = skrt_pkg::STAT_EMPTY;
               end else if (req_data.mode == skrt_pkg::MODE_LIST) begin
                  state_in = S_LIST;
               end else if (req_data.mode inside {skrt_pkg::MODE_INSERT,
                                                  skrt_pkg::MODE_LOOKUP,
                                                  skrt_pkg::MODE_UPDATE,
                                                  skrt_pkg::MODE_DELETE}) begin
                  state_in = S_SCAN;
               end
               // unused mode codes are dropped without a result
            end
         end

         S_SCAN: begin
            // read one entry a cycle, compare it the cycle after
            issue       = (idx_ff < cnt_ff);
            rd_en       = issue;
            pend_in     = issue;
            pend_idx_in = idx_ff;
            if (issue) begin
               idx_in = idx_ff + ONE;
            end
            stop    = pend_ff && !cmp.lt;
            hit_pos = stop ? pend_idx_ff : cnt_ff;
            if (stop || (!pend_ff && !issue)) begin
               pend_in  = 1'b0;
               pos_in   = hit_pos;
               state_in = S_IDLE;
               if (ins) begin
                  if (stop && cmp.eq) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = skrt_pkg::STAT_DUP;
                  end else begin
                     idx_in   = cnt_ff;
                     state_in = S_SHIFT;
                  end
               end else if (!(stop && cmp.eq)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = skrt_pkg::STAT_NOTFOUND;
               end else begin
                  case (req_ff.mode)
                     skrt_pkg::MODE_LOOKUP: begin
                        rsp_strobe_in      = 1'b1;
                        rsp_in.status      = skrt_pkg::STAT_OK;
                        rsp_in.rec_key     = rd_data.key;
                        rsp_in.rec_payload = rd_data.payload;
                     end
                     skrt_pkg::MODE_UPDATE: begin
                        wr_en              = 1'b1;
                        wr_addr            = hit_pos[AW-1:0];
                        wr_data.key        = rd_data.key;
                        wr_data.payload    = req_ff.payload;
                        rsp_strobe_in      = 1'b1;
                        rsp_in.status      = skrt_pkg::STAT_OK;
                        rsp_in.rec_key     = rd_data.key;
                        rsp_in.rec_payload = req_ff.payload;
                     end
                     default: begin
                        // delete: keep the record, then close the gap
                        fnd_in   = rd_data;
                        idx_in   = hit_pos;
                        state_in = S_SHIFT;
                     end
                  endcase
               end
            end
         end

         S_SHIFT: begin
            // read source this cycle, write it to its destination next cycle
            issue       = ins ? (idx_ff > pos_ff) : ((idx_ff + ONE) < cnt_ff);
            rd_en       = issue;
            rd_addr     = src_idx[AW-1:0];
            pend_in     = issue;
            pend_idx_in = idx_ff;
            if (issue) begin
               idx_in = src_idx;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff[AW-1:0];
               wr_data = rd_data;
            end else if (!issue) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in.status = skrt_pkg::STAT_OK;
               if (ins) begin
                  wr_en              = 1'b1;
                  wr_addr            = pos_ff[AW-1:0];
                  wr_data.key        = req_ff.key;
                  wr_data.payload    = req_ff.payload;
                  cnt_in             = cnt_ff + ONE;
                  rsp_in.rec_key     = req_ff.key;
                  rsp_in.rec_payload = req_ff.payload;
               end else begin
                  cnt_in             = cnt_ff - ONE;
                  rsp_in.rec_key     = fnd_ff.key;
                  rsp_in.rec_payload = fnd_ff.payload;
               end
            end
         end

         S_LIST: begin
            issue       = (idx_ff < cnt_ff);
            rd_en       = issue;
            pend_in     = issue;
            pend_idx_in = idx_ff;
            if (issue) begin
               idx_in = idx_ff + ONE;
            end
            if (pend_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_in.status      = skrt_pkg::STAT_OK;
               rsp_in.rec_key     = rd_data.key;
               rsp_in.rec_payload = rd_data.payload;
               rsp_in.last        = ((pend_idx_ff + ONE) == cnt_ff);
               if (rsp_in.last) begin
                  state_in = S_IDLE;
                  pend_in  = 1'b0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // count after this step, fitted to the result field
      cnt_wide           = {{skrt_pkg::CNT_W{1'b0}}, cnt_in};
      rsp_in.entry_count = cnt_wide[skrt_pkg::CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= ZERO;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
      fnd_ff      <= fnd_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ----- src/skrt_checker.sv -----
// Port-level checks for the sorted keyed record table, bound to the top level.
`default_nettype none

module skrt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire skrt_pkg::req_type req_data,
   input wire logic              rsp_strobe,
   input wire skrt_pkg::rsp_type rsp_data
);

   // a list streams without gaps until its last word
   a_list_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=> rsp_strobe)
      else $error("list stream broken before last word");

   // every error answer is a single word
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != skrt_pkg::STAT_OK) |-> rsp_data.last)
      else $error("error result not flagged last");

   // an accepted request with a valid mode either answers at once or holds busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.mode == skrt_pkg::MODE_INSERT
                          || req_data.mode == skrt_pkg::MODE_LOOKUP
                          || req_data.mode == skrt_pkg::MODE_UPDATE
                          || req_data.mode == skrt_pkg::MODE_DELETE
                          || req_data.mode == skrt_pkg::MODE_LIST))
      |=> (busy || rsp_strobe))
      else $error("accepted request made no progress");

   // empty is only reported with no records held
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == skrt_pkg::STAT_EMPTY)
      |-> (rsp_data.entry_count == '0))
      else $error("empty status with nonzero count");

endmodule

bind sorted_keyed_record_table_unit skrt_checker u_skrt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
